// ===== design/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and widths for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QW = 16;
  localparam int VW = 24;
  localparam int PW = 2 * QW + 2;        // matrix entry width (signed)
  localparam int NW = 2 * QW + 2;        // norm width (unsigned)
  localparam int CW = PW + VW + 2;       // numerator width (signed)
  localparam int MW = CW - 1;            // numerator magnitude width

  typedef struct packed {
    logic signed [QW-1:0] quat_s;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [VW-1:0] rot_x;
    logic signed [VW-1:0] rot_y;
    logic signed [VW-1:0] rot_z;
    logic                 zero_quat;
    logic                 saturated;
  } qvr_out_t;

endpackage

// ===== design/qvr_div.sv =====
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider: magnitude over norm, one quotient bit a stage.
// Quotient bits above the 24-bit result range collapse into an overflow flag.
// ----------------------------------------------------------------------------
module qvr_div (
  input  logic                      clk,
  input  logic [qvr_pkg::MW-1:0]    num,
  input  logic [qvr_pkg::NW-1:0]    den,
  input  logic                      neg,
  output logic [qvr_pkg::VW-1:0]    quo,
  output logic                      ovf,
  output logic                      neg_out
);

  localparam int QB = qvr_pkg::VW;     // quotient bits kept
  localparam int RW = qvr_pkg::NW + 1;

  logic [QB:0][qvr_pkg::MW-1:0] nm;
  logic [QB:0][qvr_pkg::NW-1:0] dn;
  logic [QB:0][RW-1:0]          rm;
  logic [QB:0][QB-1:0]          qq;
  logic [QB:0]                  ov;
  logic [QB:0]                  ng;

  // Stage 0: anything at or above den << QB overflows; remainder is the
  // top part of the numerator, known below den when no overflow.
  logic [qvr_pkg::MW-1:0] hi_part;
  assign hi_part = num >> QB;

  always_ff @(posedge clk) begin
    nm[0] <= num;
    dn[0] <= den;
    ov[0] <= ({{(qvr_pkg::MW-qvr_pkg::NW){1'b0}}, den} <= hi_part);
    rm[0] <= hi_part[RW-1:0];
    qq[0] <= '0;
    ng[0] <= neg;
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [RW:0] tr;
    logic [RW:0] df;
    always_comb begin
      tr = {rm[i], nm[i][QB-1-i]};
      df = tr - {2'b00, dn[i]};
    end
    always_ff @(posedge clk) begin
      nm[i+1] <= nm[i];
      dn[i+1] <= dn[i];
      ov[i+1] <= ov[i];
      ng[i+1] <= ng[i];
      if (!df[RW]) begin
        rm[i+1] <= df[RW-1:0];
        qq[i+1] <= {qq[i][QB-2:0], 1'b1};
      end else begin
        rm[i+1] <= tr[RW-1:0];
        qq[i+1] <= {qq[i][QB-2:0], 1'b0};
      end
    end
  end

  assign quo     = qq[QB];
  assign ovf     = ov[QB];
  assign neg_out = ng[QB];

endmodule

// ===== design/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a vector by an arbitrary quaternion, dividing by its norm.
// ----------------------------------------------------------------------------
// The block takes one beat every cycle; busy is always low. Results appear
// on done in order: product, matrix, matrix-vector and row-sum stages,
// a 25-stage divider (an overflow entry stage, then one quotient bit per
// stage), then one output register. The receiver cannot stall.
module quaternion_vector_rotate (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qvr_pkg::qvr_in_t  item,
  output logic              done,
  output qvr_pkg::qvr_out_t result
);

  localparam int QW = qvr_pkg::QW;
  localparam int PW = qvr_pkg::PW;
  localparam int CW = qvr_pkg::CW;
  localparam int NW = qvr_pkg::NW;
  localparam int MW = qvr_pkg::MW;
  localparam int VW = qvr_pkg::VW;
  localparam int LAT = VW + 6;

  assign busy = 1'b0;

  logic [LAT-2:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LAT-3:0], start & ~busy};
  end

  // Stage 1: the ten pairwise products.
  logic signed [2*QW-1:0] ss, xx, yy, zz, xy, xz, yz, sx, sy, sz;
  logic signed [VW-1:0]   u1x, u1y, u1z;
  always_ff @(posedge clk) begin
    ss <= item.quat_s * item.quat_s;
    xx <= item.quat_x * item.quat_x;
    yy <= item.quat_y * item.quat_y;
    zz <= item.quat_z * item.quat_z;
    xy <= item.quat_x * item.quat_y;
    xz <= item.quat_x * item.quat_z;
    yz <= item.quat_y * item.quat_z;
    sx <= item.quat_s * item.quat_x;
    sy <= item.quat_s * item.quat_y;
    sz <= item.quat_s * item.quat_z;
    u1x <= item.vec_x;
    u1y <= item.vec_y;
    u1z <= item.vec_z;
  end

  // Stage 2: matrix entries and norm.
  logic signed [PW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic [NW-1:0]        nrm2;
  logic signed [VW-1:0] u2x, u2y, u2z;
  function automatic logic signed [PW-1:0] ext(input logic signed [2*QW-1:0] a);
    ext = PW'(a);
  endfunction
  always_ff @(posedge clk) begin
    m00 <= ext(ss) + ext(xx) - ext(yy) - ext(zz);
    m11 <= ext(ss) - ext(xx) + ext(yy) - ext(zz);
    m22 <= ext(ss) - ext(xx) - ext(yy) + ext(zz);
    m01 <= (ext(xy) - ext(sz)) <<< 1;
    m02 <= (ext(xz) + ext(sy)) <<< 1;
    m10 <= (ext(xy) + ext(sz)) <<< 1;
    m12 <= (ext(yz) - ext(sx)) <<< 1;
    m20 <= (ext(xz) - ext(sy)) <<< 1;
    m21 <= (ext(yz) + ext(sx)) <<< 1;
    nrm2 <= NW'(unsigned'(ss)) + NW'(unsigned'(xx)) + NW'(unsigned'(yy))
          + NW'(unsigned'(zz));
    u2x <= u1x; u2y <= u1y; u2z <= u1z;
  end

  // Stage 3: the nine matrix-vector products.
  logic signed [PW+VW-1:0] p [3][3];
  logic [NW-1:0] nrm3;
  always_ff @(posedge clk) begin
    p[0][0] <= m00 * u2x; p[0][1] <= m01 * u2y; p[0][2] <= m02 * u2z;
    p[1][0] <= m10 * u2x; p[1][1] <= m11 * u2y; p[1][2] <= m12 * u2z;
    p[2][0] <= m20 * u2x; p[2][1] <= m21 * u2y; p[2][2] <= m22 * u2z;
    nrm3 <= nrm2;
  end

  // Stage 4: row sums, split into sign and magnitude.
  logic [MW-1:0] mg [3];
  logic [2:0]    sg;
  logic [NW-1:0] nrm4;
  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [CW-1:0] sum;
    always_comb begin
      sum = CW'(p[r][0]) + CW'(p[r][1]) + CW'(p[r][2]);
    end
    always_ff @(posedge clk) begin
      sg[r] <= sum[CW-1];
      mg[r] <= sum[CW-1] ? MW'(-sum) : MW'(sum);
    end
  end
  always_ff @(posedge clk) nrm4 <= nrm3;

  logic [VW-1:0] q [3];
  logic [2:0]    ovf, qn;
  logic [NW-1:0] nz_pipe;
  for (genvar r = 0; r < 3; r++) begin : g_div
    qvr_div u_div (
      .clk(clk), .num(mg[r]), .den(nrm4), .neg(sg[r]),
      .quo(q[r]), .ovf(ovf[r]), .neg_out(qn[r])
    );
  end

  logic [VW:0] zflag;
  always_ff @(posedge clk) zflag <= {zflag[VW-1:0], nrm4 == '0};

  // Output: sign, saturate, register.
  logic [VW-1:0] rv [3];
  logic [2:0]    sat;
  for (genvar r = 0; r < 3; r++) begin : g_sat
    localparam logic [VW-1:0] MAXP = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MINN = {1'b1, {(VW-1){1'b0}}};
    always_comb begin
      if (!qn[r]) begin
        sat[r] = ovf[r] | q[r][VW-1];
        rv[r]  = sat[r] ? MAXP : q[r];
      end else begin
        sat[r] = ovf[r] | (q[r] > MINN);
        rv[r]  = sat[r] ? MINN : -q[r];
      end
    end
  end
  assign nz_pipe = '0;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[LAT-2];
    if (zflag[VW]) begin
      result <= '{rot_x: '0, rot_y: '0, rot_z: '0, zero_quat: 1'b1, saturated: 1'b0};
    end else begin
      result <= '{rot_x: rv[0], rot_y: rv[1], rot_z: rv[2], zero_quat: 1'b0,
                  saturated: |sat | (nz_pipe != '0)};
    end
  end

  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[LAT-2])) else $error("done without matching beat");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_quat) |-> (result.rot_x == '0 && !result.saturated))
    else $error("zero quaternion result not cleared");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

// ===== tb/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker
// Watches the command and result channels of the quaternion rotator, works
// out each expected rotated vector with exact wide arithmetic, and compares.
// ----------------------------------------------------------------------------
module qvr_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  qvr_pkg::qvr_in_t  item,
  input  logic              done,
  input  qvr_pkg::qvr_out_t result,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  qvr_pkg::qvr_out_t rotations[$];

  function automatic logic signed [qvr_pkg::VW-1:0] clamp_quotient(
      logic signed [127:0] num, logic signed [127:0] den, ref logic sat);
    logic signed [127:0] q;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    q = num / den;
    hi_lim = (128'sd1 <<< (qvr_pkg::VW - 1)) - 1;
    lo_lim = -(128'sd1 <<< (qvr_pkg::VW - 1));
    if (q > hi_lim) begin
      sat = 1'b1;
      return hi_lim[qvr_pkg::VW-1:0];
    end
    if (q < lo_lim) begin
      sat = 1'b1;
      return lo_lim[qvr_pkg::VW-1:0];
    end
    return q[qvr_pkg::VW-1:0];
  endfunction

  function automatic qvr_pkg::qvr_out_t rotate_vector(qvr_pkg::qvr_in_t b);
    logic signed [127:0] s, x, y, z, ux, uy, uz, n, cx, cy, cz;
    logic sat;
    qvr_pkg::qvr_out_t r;
    s = b.quat_s; x = b.quat_x; y = b.quat_y; z = b.quat_z;
    ux = b.vec_x; uy = b.vec_y; uz = b.vec_z;
    r = '0;
    sat = 1'b0;
    n = s*s + x*x + y*y + z*z;
    if (n == 0) begin
      r.zero_quat = 1'b1;
      return r;
    end
    cx = (s*s + x*x - y*y - z*z)*ux + 2*(x*y - s*z)*uy + 2*(x*z + s*y)*uz;
    cy = 2*(x*y + s*z)*ux + (s*s - x*x + y*y - z*z)*uy + 2*(y*z - s*x)*uz;
    cz = 2*(x*z - s*y)*ux + 2*(y*z + s*x)*uy + (s*s - x*x - y*y + z*z)*uz;
    r.rot_x = clamp_quotient(cx, n, sat);
    r.rot_y = clamp_quotient(cy, n, sat);
    r.rot_z = clamp_quotient(cz, n, sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    qvr_pkg::qvr_out_t want;
    if (!rst) begin
      if (start && !busy) rotations.push_back(rotate_vector(item));
      if (done) begin
        if (rotations.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = rotations.pop_front();
          if (result.rot_x !== want.rot_x) report_mismatch("rot_x", result.rot_x, want.rot_x);
          if (result.rot_y !== want.rot_y) report_mismatch("rot_y", result.rot_y, want.rot_y);
          if (result.rot_z !== want.rot_z) report_mismatch("rot_z", result.rot_z, want.rot_z);
          if (result.zero_quat !== want.zero_quat)
            report_mismatch("zero_quat", result.zero_quat, want.zero_quat);
          if (result.saturated !== want.saturated)
            report_mismatch("saturated", result.saturated, want.saturated);
        end
      end
    end
    pending = rotations.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random quaternion and vector beats into the rotator;
// part of the random run has random gaps. Verdict: the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QW = qvr_pkg::QW;
  localparam int VW = qvr_pkg::VW;
  localparam int LATENCY = 30;
  localparam int IDLE_LIMIT = 2000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  qvr_pkg::qvr_in_t  item;
  logic              done;
  qvr_pkg::qvr_out_t result;
  int                errors;
  int                pending;
  int                idle_cycles;

  quaternion_vector_rotate DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  qvr_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [QW-1:0] pick_quat(int mode);
    case (mode)
      0: return {1'b1, {(QW-1){1'b0}}};
      1: return {1'b0, {(QW-1){1'b1}}};
      2: return QW'(1 << (QW - 2));
      3: return QW'($urandom_range(0, 7)) - QW'(3);
      default: return QW'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_vec(int mode);
    case (mode)
      0: return {1'b1, {(VW-1){1'b0}}};
      1: return {1'b0, {(VW-1){1'b1}}};
      2: return VW'($urandom_range(0, 8192)) - VW'(4096);
      default: return VW'($urandom);
    endcase
  endfunction

  // Holds the beat until the block takes it, then, if gaps is set, idles at random.
  task automatic send_beat(qvr_pkg::qvr_in_t b, bit gaps);
    item <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (gaps) begin
      while ($urandom_range(0, 99) < 18) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  task automatic send_random(bit gaps);
    qvr_pkg::qvr_in_t b;
    int qm;
    qm = $urandom_range(0, 9);
    b.quat_s = pick_quat(qm < 6 ? 4 : $urandom_range(0, 4));
    b.quat_x = pick_quat(qm < 6 ? 4 : $urandom_range(0, 4));
    b.quat_y = pick_quat(qm < 6 ? 4 : $urandom_range(0, 4));
    b.quat_z = pick_quat(qm < 6 ? 4 : $urandom_range(0, 4));
    if ($urandom_range(0, 49) == 0) begin
      b.quat_s = '0; b.quat_x = '0; b.quat_y = '0; b.quat_z = '0;
    end
    b.vec_x = pick_vec($urandom_range(0, 5));
    b.vec_y = pick_vec($urandom_range(0, 5));
    b.vec_z = pick_vec($urandom_range(0, 5));
    send_beat(b, gaps);
  endtask

  initial begin
    qvr_pkg::qvr_in_t b;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero quaternion, identity, extreme codes, tiny norms (some saturate).
    send_beat('0, 1'b0);
    b = '0; b.quat_s = QW'(1 << (QW - 2)); b.vec_x = pick_vec(1); b.vec_y = pick_vec(0);
    b.vec_z = VW'(12345);
    send_beat(b, 1'b0);
    for (int i = 0; i < 4; i++) begin
      b.quat_s = pick_quat(i % 2); b.quat_x = pick_quat((i / 2) % 2);
      b.quat_y = pick_quat(i % 2); b.quat_z = pick_quat(1 - i % 2);
      b.vec_x = pick_vec(i % 2); b.vec_y = pick_vec(1 - i % 2); b.vec_z = pick_vec(0);
      send_beat(b, 1'b0);
    end
    for (int i = 0; i < 4; i++) begin
      b = '0;
      b.vec_x = pick_vec(1); b.vec_y = pick_vec(0); b.vec_z = pick_vec(1);
      case (i)
        0: b.quat_s = QW'(1);
        1: b.quat_x = '1;
        2: b.quat_y = QW'(1);
        default: b.quat_z = '1;
      endcase
      send_beat(b, 1'b0);
    end
    b = '1; send_beat(b, 1'b0);

    for (int i = 0; i < 1040; i++) send_random(i < 300 || i >= 500);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
